// ===== design/psfw_pkg.sv =====
package psfw_pkg;

  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_SQ   = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_THR  = 3'd6;
  localparam logic [2:0] OP_END  = 3'd7;

  localparam logic [1:0] FL_NONE = 2'd0;
  localparam logic [1:0] FL_FZ   = 2'd1;
  localparam logic [1:0] FL_FA   = 2'd2;
  localparam logic [1:0] FL_FO   = 2'd3;

  // Operand codes below 32 name flip-flops, codes from 32 up name the scratch memory.
  localparam logic [5:0] R_P0    = 6'd0;
  localparam logic [5:0] R_P1    = 6'd1;
  localparam logic [5:0] R_P2    = 6'd2;
  localparam logic [5:0] R_N0    = 6'd3;
  localparam logic [5:0] R_N1    = 6'd4;
  localparam logic [5:0] R_N2    = 6'd5;
  localparam logic [5:0] R_F0    = 6'd6;
  localparam logic [5:0] R_F1    = 6'd7;
  localparam logic [5:0] R_F2    = 6'd8;
  localparam logic [5:0] R_M0    = 6'd9;
  localparam logic [5:0] R_M1    = 6'd10;
  localparam logic [5:0] R_M2    = 6'd11;
  localparam logic [5:0] R_G0    = 6'd12;
  localparam logic [5:0] R_G1    = 6'd13;
  localparam logic [5:0] R_G2    = 6'd14;
  localparam logic [5:0] R_MASS  = 6'd15;
  localparam logic [5:0] R_INVDT = 6'd16;
  localparam logic [5:0] R_PV0   = 6'd17;
  localparam logic [5:0] R_PV1   = 6'd18;
  localparam logic [5:0] R_PV2   = 6'd19;
  localparam logic [5:0] R_Z0    = 6'd20;
  localparam logic [5:0] R_Z1    = 6'd21;
  localparam logic [5:0] R_Z2    = 6'd22;
  localparam logic [5:0] R_C0    = 6'd23;
  localparam logic [5:0] R_C1    = 6'd24;
  localparam logic [5:0] R_C2    = 6'd25;
  localparam logic [5:0] R_V0    = 6'd26;
  localparam logic [5:0] R_V1    = 6'd27;
  localparam logic [5:0] R_V2    = 6'd28;
  localparam logic [5:0] R_A0    = 6'd29;
  localparam logic [5:0] R_A1    = 6'd30;
  localparam logic [5:0] R_A2    = 6'd31;
  localparam logic [5:0] R_T0    = 6'd32;
  localparam logic [5:0] R_T1    = 6'd33;
  localparam logic [5:0] R_MP0   = 6'd34;
  localparam logic [5:0] R_MP1   = 6'd35;
  localparam logic [5:0] R_MP2   = 6'd36;
  localparam logic [5:0] R_NF    = 6'd37;
  localparam logic [5:0] R_NX0   = 6'd38;
  localparam logic [5:0] R_NX1   = 6'd39;
  localparam logic [5:0] R_NX2   = 6'd40;
  localparam logic [5:0] R_D     = 6'd41;
  localparam logic [5:0] R_FSQ   = 6'd42;
  localparam logic [5:0] R_S     = 6'd43;
  localparam logic [5:0] R_DEN   = 6'd44;
  localparam logic [5:0] R_LAM   = 6'd45;

  localparam int unsigned ScrDepth = 16;
  localparam int unsigned DivSteps = 48;
  localparam int unsigned SqrtSteps = 24;

  localparam logic [2:0] CFG_CONTACT_X = 3'd0;
  localparam logic [2:0] CFG_CONTACT_Y = 3'd1;
  localparam logic [2:0] CFG_CONTACT_Z = 3'd2;
  localparam logic [2:0] CFG_NORMAL_X  = 3'd3;
  localparam logic [2:0] CFG_NORMAL_Y  = 3'd4;
  localparam logic [2:0] CFG_NORMAL_Z  = 3'd5;
  localparam logic [2:0] CFG_MASS      = 3'd6;
  localparam logic [2:0] CFG_INV_STEP  = 3'd7;

  localparam logic [2:0] KIND_ZMP   = 3'd0;
  localparam logic [2:0] KIND_COM   = 3'd1;
  localparam logic [2:0] KIND_VEL   = 3'd2;
  localparam logic [2:0] KIND_ACC   = 3'd3;
  localparam logic [2:0] KIND_OMEGA = 3'd4;

  localparam logic [63:0] FsqThresh = 64'd42 << 32;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
    logic [1:0] flg;
  } uop_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [5:0] a, input logic [5:0] b,
                              input logic [5:0] d, input logic [1:0] flg);
    uop_t u;
    u.op = op;
    u.a = a;
    u.b = b;
    u.d = d;
    u.flg = flg;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [6:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_SQ,  R_F0, R_F0, R_T0, FL_NONE);
      7'd1:  u = mk(OP_SQ,  R_F1, R_F1, R_T0, FL_NONE);
      7'd2:  u = mk(OP_SQ,  R_F2, R_F2, R_T0, FL_NONE);
      7'd3:  u = mk(OP_THR, R_T0, R_T0, R_FSQ, FL_NONE);
      7'd4:  u = mk(OP_MUL, R_P1, R_F2, R_T0, FL_NONE);
      7'd5:  u = mk(OP_MUL, R_P2, R_F1, R_T1, FL_NONE);
      7'd6:  u = mk(OP_SUB, R_T0, R_T1, R_MP0, FL_NONE);
      7'd7:  u = mk(OP_SUB, R_M0, R_MP0, R_MP0, FL_NONE);
      7'd8:  u = mk(OP_MUL, R_P2, R_F0, R_T0, FL_NONE);
      7'd9:  u = mk(OP_MUL, R_P0, R_F2, R_T1, FL_NONE);
      7'd10: u = mk(OP_SUB, R_T0, R_T1, R_MP1, FL_NONE);
      7'd11: u = mk(OP_SUB, R_M1, R_MP1, R_MP1, FL_NONE);
      7'd12: u = mk(OP_MUL, R_P0, R_F1, R_T0, FL_NONE);
      7'd13: u = mk(OP_MUL, R_P1, R_F0, R_T1, FL_NONE);
      7'd14: u = mk(OP_SUB, R_T0, R_T1, R_MP2, FL_NONE);
      7'd15: u = mk(OP_SUB, R_M2, R_MP2, R_MP2, FL_NONE);
      7'd16: u = mk(OP_MUL, R_N0, R_F0, R_T0, FL_NONE);
      7'd17: u = mk(OP_MUL, R_N1, R_F1, R_T1, FL_NONE);
      7'd18: u = mk(OP_ADD, R_T0, R_T1, R_NF, FL_NONE);
      7'd19: u = mk(OP_MUL, R_N2, R_F2, R_T0, FL_NONE);
      7'd20: u = mk(OP_ADD, R_NF, R_T0, R_NF, FL_NONE);
      7'd21: u = mk(OP_MUL, R_N1, R_MP2, R_T0, FL_NONE);
      7'd22: u = mk(OP_MUL, R_N2, R_MP1, R_T1, FL_NONE);
      7'd23: u = mk(OP_SUB, R_T0, R_T1, R_NX0, FL_NONE);
      7'd24: u = mk(OP_MUL, R_N2, R_MP0, R_T0, FL_NONE);
      7'd25: u = mk(OP_MUL, R_N0, R_MP2, R_T1, FL_NONE);
      7'd26: u = mk(OP_SUB, R_T0, R_T1, R_NX1, FL_NONE);
      7'd27: u = mk(OP_MUL, R_N0, R_MP1, R_T0, FL_NONE);
      7'd28: u = mk(OP_MUL, R_N1, R_MP0, R_T1, FL_NONE);
      7'd29: u = mk(OP_SUB, R_T0, R_T1, R_NX2, FL_NONE);
      7'd30: u = mk(OP_DIV, R_NX0, R_NF, R_T0, FL_FZ);
      7'd31: u = mk(OP_ADD, R_P0, R_T0, R_Z0, FL_NONE);
      7'd32: u = mk(OP_DIV, R_NX1, R_NF, R_T0, FL_FZ);
      7'd33: u = mk(OP_ADD, R_P1, R_T0, R_Z1, FL_NONE);
      7'd34: u = mk(OP_DIV, R_NX2, R_NF, R_T0, FL_FZ);
      7'd35: u = mk(OP_ADD, R_P2, R_T0, R_Z2, FL_NONE);
      7'd36: u = mk(OP_SUB, R_G0, R_Z0, R_T0, FL_NONE);
      7'd37: u = mk(OP_MUL, R_F0, R_T0, R_D, FL_NONE);
      7'd38: u = mk(OP_SUB, R_G1, R_Z1, R_T0, FL_NONE);
      7'd39: u = mk(OP_MUL, R_F1, R_T0, R_T1, FL_NONE);
      7'd40: u = mk(OP_ADD, R_D, R_T1, R_D, FL_NONE);
      7'd41: u = mk(OP_SUB, R_G2, R_Z2, R_T0, FL_NONE);
      7'd42: u = mk(OP_MUL, R_F2, R_T0, R_T1, FL_NONE);
      7'd43: u = mk(OP_ADD, R_D, R_T1, R_D, FL_NONE);
      7'd44: u = mk(OP_DIV, R_D, R_FSQ, R_S, FL_FZ);
      7'd45: u = mk(OP_MUL, R_S, R_F0, R_T0, FL_NONE);
      7'd46: u = mk(OP_ADD, R_Z0, R_T0, R_C0, FL_NONE);
      7'd47: u = mk(OP_MUL, R_S, R_F1, R_T0, FL_NONE);
      7'd48: u = mk(OP_ADD, R_Z1, R_T0, R_C1, FL_NONE);
      7'd49: u = mk(OP_MUL, R_S, R_F2, R_T0, FL_NONE);
      7'd50: u = mk(OP_ADD, R_Z2, R_T0, R_C2, FL_NONE);
      7'd51: u = mk(OP_SUB, R_C0, R_PV0, R_T0, FL_NONE);
      7'd52: u = mk(OP_MUL, R_T0, R_INVDT, R_V0, FL_NONE);
      7'd53: u = mk(OP_SUB, R_C1, R_PV1, R_T0, FL_NONE);
      7'd54: u = mk(OP_MUL, R_T0, R_INVDT, R_V1, FL_NONE);
      7'd55: u = mk(OP_SUB, R_C2, R_PV2, R_T0, FL_NONE);
      7'd56: u = mk(OP_MUL, R_T0, R_INVDT, R_V2, FL_NONE);
      7'd57: u = mk(OP_DIV, R_F0, R_MASS, R_A0, FL_FA);
      7'd58: u = mk(OP_DIV, R_F1, R_MASS, R_A1, FL_FA);
      7'd59: u = mk(OP_DIV, R_F2, R_MASS, R_A2, FL_FA);
      7'd60: u = mk(OP_SUB, R_C0, R_Z0, R_T0, FL_NONE);
      7'd61: u = mk(OP_MUL, R_N0, R_T0, R_D, FL_NONE);
      7'd62: u = mk(OP_SUB, R_C1, R_Z1, R_T0, FL_NONE);
      7'd63: u = mk(OP_MUL, R_N1, R_T0, R_T1, FL_NONE);
      7'd64: u = mk(OP_ADD, R_D, R_T1, R_D, FL_NONE);
      7'd65: u = mk(OP_SUB, R_C2, R_Z2, R_T0, FL_NONE);
      7'd66: u = mk(OP_MUL, R_N2, R_T0, R_T1, FL_NONE);
      7'd67: u = mk(OP_ADD, R_D, R_T1, R_D, FL_NONE);
      7'd68: u = mk(OP_MUL, R_MASS, R_D, R_DEN, FL_NONE);
      7'd69: u = mk(OP_DIV, R_NF, R_DEN, R_LAM, FL_FO);
      7'd70: u = mk(OP_SQRT, R_LAM, R_LAM, R_T0, FL_FO);
      default: u = mk(OP_END, R_T0, R_T0, R_T0, FL_NONE);
    endcase
    return u;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] x);
    if (x[32] == x[31]) begin
      return x[31:0];
    end
    return x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] sat48(input logic [47:0] x);
    if (x[47:31] == '0 || x[47:31] == '1) begin
      return x[31:0];
    end
    return x[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] div_sat(input logic [47:0] q, input logic neg);
    if (neg) begin
      if (q > 48'h8000_0000) begin
        return 32'h8000_0000;
      end
      return ~q[31:0] + 32'd1;
    end
    if (q > 48'h7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

// ===== design/pendulum_state_from_wrench_core.sv =====
// Turns one contact wrench transaction (force, moment about the origin, CoM guess) into five
// Q16.16 results: ZMP, CoM, CoM velocity, CoM acceleration and omega, in that order, the last
// one flagged by last_o. A wrench whose squared force is below 42 produces no result and
// leaves the stored CoM untouched. A full item, once its program has run, gives one result
// per cycle while out_stall_i is low. The work is done by one shared multiplier, adder and
// compare-subtract unit stepped through a program of 62 arithmetic steps, eight radix-2
// divisions and one square root. A division by zero, or the square root of a negative
// value, skips the iterations instead, so such an item finishes sooner. No new wrench is
// taken until all five results are delivered. Configuration writes are taken only while
// the block is idle.
module pendulum_state_from_wrench_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic signed [31:0] force_z_i,
  input  logic signed [31:0] moment_x_i,
  input  logic signed [31:0] moment_y_i,
  input  logic signed [31:0] moment_z_i,
  input  logic signed [31:0] guess_x_i,
  input  logic signed [31:0] guess_y_i,
  input  logic signed [31:0] guess_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic               last_o,
  output logic               fault_o
);
  import psfw_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_ITER = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_q;
  logic [6:0]  pc_q;
  logic [5:0]  cnt_q;
  logic [2:0]  kind_q;
  logic        fz_q, fa_q, fo_q;

  logic [31:0] p_q [3];
  logic [17:0] n_q [3];
  logic [30:0] mass_q;
  logic [30:0] invdt_q;
  logic [31:0] prev_q [3];

  logic [31:0] f_q [3];
  logic [31:0] m_q [3];
  logic [31:0] g_q [3];
  logic [31:0] z_q [3];
  logic [31:0] c_q [3];
  logic [31:0] v_q [3];
  logic [31:0] a_q [3];
  logic [31:0] om_q;

  logic [31:0] scr_q [ScrDepth];
  logic [31:0] rda_q, rdb_q, fla_q, flb_q;
  logic [63:0] prod_q;
  logic [63:0] fsq_q;
  logic [31:0] res_q;
  logic [47:0] dvd_q;
  logic [31:0] dvs_q;
  logic [32:0] rem_q;
  logic        neg_q;

  uop_t        u;
  logic [31:0] opa, opb, wb_val, fsq16;
  logic        in_acc, cfg_acc, wr_en, is_div;
  logic [32:0] iter_l, iter_r, iter_diff;
  logic        iter_ge;

  function automatic logic [31:0] src_val(input logic [5:0] c);
    case (c)
      R_P0:    return p_q[0];
      R_P1:    return p_q[1];
      R_P2:    return p_q[2];
      R_N0:    return {{14{n_q[0][17]}}, n_q[0]};
      R_N1:    return {{14{n_q[1][17]}}, n_q[1]};
      R_N2:    return {{14{n_q[2][17]}}, n_q[2]};
      R_F0:    return f_q[0];
      R_F1:    return f_q[1];
      R_F2:    return f_q[2];
      R_M0:    return m_q[0];
      R_M1:    return m_q[1];
      R_M2:    return m_q[2];
      R_G0:    return g_q[0];
      R_G1:    return g_q[1];
      R_G2:    return g_q[2];
      R_MASS:  return {1'b0, mass_q};
      R_INVDT: return {1'b0, invdt_q};
      R_PV0:   return prev_q[0];
      R_PV1:   return prev_q[1];
      R_PV2:   return prev_q[2];
      R_Z0:    return z_q[0];
      R_Z1:    return z_q[1];
      R_Z2:    return z_q[2];
      R_C0:    return c_q[0];
      R_C1:    return c_q[1];
      R_C2:    return c_q[2];
      default: return 32'd0;
    endcase
  endfunction

  assign u           = uop_at(pc_q);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign opa         = u.a[5] ? rda_q : fla_q;
  assign opb         = u.b[5] ? rdb_q : flb_q;
  assign fsq16       = (fsq_q[63:16] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : fsq_q[47:16];
  assign is_div      = (u.op == OP_DIV);

  // Shared compare-subtract: one restoring division bit or one square-root bit per cycle.
  assign iter_l    = is_div ? {rem_q[31:0], dvd_q[47]} : {rem_q[30:0], dvd_q[47:46]};
  assign iter_r    = is_div ? {1'b0, dvs_q} : {dvs_q[30:0], 2'b01};
  assign iter_ge   = (iter_l >= iter_r);
  assign iter_diff = iter_l - iter_r;

  always_comb begin
    case (u.op)
      OP_MUL:  wb_val = sat48(prod_q[63:16]);
      OP_DIV:  wb_val = div_sat(dvd_q, neg_q);
      default: wb_val = res_q;
    endcase
  end

  assign wr_en = (state_q == ST_WB) && u.d[5] &&
                 (u.op inside {OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_THR});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      scr_q[u.d[3:0]] <= wb_val;
    end
    rda_q <= scr_q[u.a[3:0]];
    rdb_q <= scr_q[u.b[3:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_q[0] <= force_x_i;
      f_q[1] <= force_y_i;
      f_q[2] <= force_z_i;
      m_q[0] <= moment_x_i;
      m_q[1] <= moment_y_i;
      m_q[2] <= moment_z_i;
      g_q[0] <= guess_x_i;
      g_q[1] <= guess_y_i;
      g_q[2] <= guess_z_i;
      fsq_q  <= '0;
    end
    case (state_q)
      ST_READ: begin
        fla_q <= src_val(u.a);
        flb_q <= src_val(u.b);
      end
      ST_EXEC: begin
        case (u.op)
          OP_MUL, OP_SQ: prod_q <= 64'($signed(opa) * $signed(opb));
          OP_ADD: res_q <= sat33({opa[31], opa} + {opb[31], opb});
          OP_SUB: res_q <= sat33({opa[31], opa} - {opb[31], opb});
          OP_THR: res_q <= fsq16;
          OP_DIV: begin
            neg_q <= opa[31] ^ opb[31];
            dvs_q <= mag(opb);
            rem_q <= '0;
            dvd_q <= (opb == 32'd0) ? 48'd0 : {mag(opa), 16'd0};
          end
          OP_SQRT: begin
            rem_q <= '0;
            dvs_q <= '0;
            dvd_q <= {1'b0, opa[30:0], 16'd0};
          end
          default: begin
          end
        endcase
      end
      ST_ITER: begin
        rem_q <= iter_ge ? iter_diff : iter_l;
        if (is_div) begin
          dvd_q <= {dvd_q[46:0], iter_ge};
        end else begin
          dvs_q <= {dvs_q[30:0], iter_ge};
          dvd_q <= {dvd_q[45:0], 2'b00};
        end
      end
      ST_WB: begin
        if (u.op == OP_SQ) begin
          fsq_q <= fsq_q + prod_q;
        end
        if (u.op == OP_SQRT) begin
          om_q <= dvs_q;
        end
        if (u.op inside {OP_MUL, OP_ADD, OP_SUB, OP_DIV} && !u.d[5]) begin
          case (u.d)
            R_Z0:    z_q[0] <= wb_val;
            R_Z1:    z_q[1] <= wb_val;
            R_Z2:    z_q[2] <= wb_val;
            R_C0:    c_q[0] <= wb_val;
            R_C1:    c_q[1] <= wb_val;
            R_C2:    c_q[2] <= wb_val;
            R_V0:    v_q[0] <= wb_val;
            R_V1:    v_q[1] <= wb_val;
            R_V2:    v_q[2] <= wb_val;
            R_A0:    a_q[0] <= wb_val;
            R_A1:    a_q[1] <= wb_val;
            R_A2:    a_q[2] <= wb_val;
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      cnt_q     <= '0;
      kind_q    <= KIND_ZMP;
      fz_q      <= 1'b0;
      fa_q      <= 1'b0;
      fo_q      <= 1'b0;
      p_q[0]    <= '0;
      p_q[1]    <= '0;
      p_q[2]    <= '0;
      n_q[0]    <= '0;
      n_q[1]    <= '0;
      n_q[2]    <= 18'd65536;
      mass_q    <= 31'd65536;
      invdt_q   <= 31'd13107200;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      prev_q[2] <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_acc) begin
            case (cfg_index_i)
              CFG_CONTACT_X: p_q[0] <= cfg_data_i;
              CFG_CONTACT_Y: p_q[1] <= cfg_data_i;
              CFG_CONTACT_Z: p_q[2] <= cfg_data_i;
              CFG_NORMAL_X:  n_q[0] <= cfg_data_i[17:0];
              CFG_NORMAL_Y:  n_q[1] <= cfg_data_i[17:0];
              CFG_NORMAL_Z:  n_q[2] <= cfg_data_i[17:0];
              CFG_MASS:      mass_q <= cfg_data_i[30:0];
              CFG_INV_STEP:  invdt_q <= cfg_data_i[30:0];
              default: begin
              end
            endcase
          end
          if (in_acc) begin
            state_q <= ST_READ;
            pc_q    <= '0;
            fz_q    <= 1'b0;
            fa_q    <= 1'b0;
            fo_q    <= 1'b0;
          end
        end
        ST_READ: begin
          if (u.op == OP_END) begin
            prev_q[0] <= c_q[0];
            prev_q[1] <= c_q[1];
            prev_q[2] <= c_q[2];
            kind_q    <= KIND_ZMP;
            state_q   <= ST_OUT;
          end else begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (u.op)
            OP_THR: begin
              state_q <= (fsq_q < FsqThresh) ? ST_IDLE : ST_WB;
            end
            OP_DIV: begin
              if (opb == 32'd0) begin
                case (u.flg)
                  FL_FZ:   fz_q <= 1'b1;
                  FL_FA:   fa_q <= 1'b1;
                  FL_FO:   fo_q <= 1'b1;
                  default: begin
                  end
                endcase
                state_q <= ST_WB;
              end else begin
                cnt_q   <= 6'(DivSteps - 1);
                state_q <= ST_ITER;
              end
            end
            OP_SQRT: begin
              if (opa[31]) begin
                fo_q    <= 1'b1;
                state_q <= ST_WB;
              end else begin
                cnt_q   <= 6'(SqrtSteps - 1);
                state_q <= ST_ITER;
              end
            end
            default: state_q <= ST_WB;
          endcase
        end
        ST_ITER: begin
          if (cnt_q == '0) begin
            state_q <= ST_WB;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_WB: begin
          pc_q    <= pc_q + 7'd1;
          state_q <= ST_READ;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            if (kind_q == KIND_OMEGA) begin
              state_q <= ST_IDLE;
            end else begin
              kind_q <= kind_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign kind_o      = kind_q;
  assign last_o      = (kind_q == KIND_OMEGA);

  always_comb begin
    case (kind_q)
      KIND_ZMP: begin
        value_x_o = z_q[0];
        value_y_o = z_q[1];
        value_z_o = z_q[2];
        fault_o   = fz_q;
      end
      KIND_COM: begin
        value_x_o = c_q[0];
        value_y_o = c_q[1];
        value_z_o = c_q[2];
        fault_o   = fz_q;
      end
      KIND_VEL: begin
        value_x_o = v_q[0];
        value_y_o = v_q[1];
        value_z_o = v_q[2];
        fault_o   = fz_q;
      end
      KIND_ACC: begin
        value_x_o = a_q[0];
        value_y_o = a_q[1];
        value_z_o = a_q[2];
        fault_o   = fa_q;
      end
      default: begin
        value_x_o = om_q;
        value_y_o = '0;
        value_z_o = '0;
        fault_o   = fz_q | fo_q;
      end
    endcase
  end

endmodule
